FILE: src/ica_pkg.sv
package ica_pkg;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_MOD = 3'd4,
		CMD_POW = 3'd5,
		CMD_PAR = 3'd6
	} cmd_t;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_ALU   = 9'b000000010,
		ST_ABSA  = 9'b000000100,
		ST_ABSB  = 9'b000001000,
		ST_DIV   = 9'b000010000,
		ST_FIX   = 9'b000100000,
		ST_MUL   = 9'b001000000,
		ST_PWBIT = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	typedef enum logic [1:0] {
		MK_PLAIN = 2'd0,
		MK_ACC   = 2'd1,
		MK_SQ    = 2'd2
	} mul_kind_t;

	typedef struct packed {
		logic done;
		logic status;
	} rsp_ctl_t;

endpackage

FILE: src/ica_if.sv
interface ica_req_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic [2:0]                   cmd;
	logic signed [DATA_WIDTH-1:0] operand_a;
	logic signed [DATA_WIDTH-1:0] operand_b;

	modport source (output valid, output cmd, output operand_a, output operand_b, input ready);
	modport sink (input valid, input cmd, input operand_a, input operand_b, output ready);
endinterface

interface ica_rsp_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] result_value;
	logic                         status;

	modport source (output valid, output result_value, output status, input ready);
	modport sink (input valid, input result_value, input status, output ready);
endinterface

FILE: src/ica_adder.sv
module ica_adder #(
	parameter int DATA_WIDTH = 32
) (
	input  logic [DATA_WIDTH-1:0] x,
	input  logic [DATA_WIDTH-1:0] y,
	input  logic                  sub,
	output logic [DATA_WIDTH-1:0] sum,
	output logic                  carry
);
	logic [DATA_WIDTH-1:0] y_eff;

	assign y_eff = sub ? ~y : y;
	assign {carry, sum} = {1'b0, x} + {1'b0, y_eff} + {{DATA_WIDTH{1'b0}}, sub};
endmodule

FILE: src/ica_core.sv
module ica_core #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2:0]            cmd,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	input  logic                  out_free,
	output logic                  idle,
	output logic [DATA_WIDTH-1:0] res,
	output ica_pkg::rsp_ctl_t     ctl
);
	import ica_pkg::*;

	localparam int CntW = $clog2(DATA_WIDTH);

	state_t                state_q;
	cmd_t                  cmd_q;
	mul_kind_t             mk_q;
	logic [DATA_WIDTH-1:0] a_q, b_q, rem_q, prod_q, mc_q, mp_q, acc_q, res_q;
	logic [CntW-1:0]       cnt_q;
	logic                  negq_q, nega_q, pw_sq_q, status_q;

	logic [DATA_WIDTH-1:0] add_x, add_y, add_sum, fix_val;
	logic                  add_sub, add_carry, fix_neg;

	ica_adder #(.DATA_WIDTH(DATA_WIDTH)) u_adder (
		.x     (add_x),
		.y     (add_y),
		.sub   (add_sub),
		.sum   (add_sum),
		.carry (add_carry)
	);

	assign fix_val = (cmd_q == CMD_DIV) ? a_q : rem_q;
	assign fix_neg = (cmd_q == CMD_DIV) ? negq_q : nega_q;

	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		case (state_q)
			ST_ALU: begin
				add_x   = a_q;
				add_y   = b_q;
				add_sub = (cmd_q == CMD_SUB);
			end
			ST_ABSA: begin
				add_y   = a_q;
				add_sub = 1'b1;
			end
			ST_ABSB: begin
				add_y   = b_q;
				add_sub = 1'b1;
			end
			ST_DIV: begin
				add_x   = {rem_q[DATA_WIDTH-2:0], a_q[DATA_WIDTH-1]};
				add_y   = b_q;
				add_sub = 1'b1;
			end
			ST_FIX: begin
				add_y   = fix_val;
				add_sub = 1'b1;
			end
			ST_MUL: begin
				add_x = prod_q;
				add_y = mc_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (cmd_t'(cmd))
							CMD_ADD, CMD_SUB: state_q <= ST_ALU;
							CMD_MUL:          state_q <= ST_MUL;
							CMD_DIV, CMD_MOD: state_q <= (b == '0) ? ST_DONE : ST_ABSA;
							CMD_POW: begin
								state_q <= (b[DATA_WIDTH-1] || b == '0) ? ST_DONE : ST_PWBIT;
							end
							default:          state_q <= ST_DONE;
						endcase
					end
				end
				ST_ALU:  state_q <= ST_DONE;
				ST_ABSA: state_q <= ST_ABSB;
				ST_ABSB: state_q <= ST_DIV;
				ST_DIV:  state_q <= (cnt_q == '0) ? ST_FIX : ST_DIV;
				ST_FIX:  state_q <= ST_DONE;
				ST_MUL: begin
					if (mp_q == '0) begin
						state_q <= (mk_q == MK_PLAIN) ? ST_DONE : ST_PWBIT;
					end
				end
				ST_PWBIT: begin
					if (b_q[0] && !pw_sq_q) begin
						state_q <= ST_MUL;
					end else if (b_q[DATA_WIDTH-1:1] == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q    <= cmd_t'(cmd);
					a_q      <= a;
					b_q      <= b;
					mc_q     <= a;
					mp_q     <= b;
					prod_q   <= '0;
					mk_q     <= MK_PLAIN;
					acc_q    <= {{(DATA_WIDTH-1){1'b0}}, 1'b1};
					pw_sq_q  <= 1'b0;
					negq_q   <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
					nega_q   <= a[DATA_WIDTH-1];
					status_q <= (cmd inside {CMD_DIV, CMD_MOD}) && (b == '0);
					case (cmd_t'(cmd))
						CMD_POW: res_q <= {{(DATA_WIDTH-1){1'b0}}, 1'b1};
						CMD_PAR: res_q <= {{(DATA_WIDTH-1){1'b0}}, a[0]};
						default: res_q <= '0;
					endcase
				end
			end
			ST_ALU: res_q <= add_sum;
			ST_ABSA: begin
				if (a_q[DATA_WIDTH-1]) begin
					a_q <= add_sum;
				end
			end
			ST_ABSB: begin
				if (b_q[DATA_WIDTH-1]) begin
					b_q <= add_sum;
				end
				rem_q <= '0;
				cnt_q <= CntW'(DATA_WIDTH - 1);
			end
			ST_DIV: begin
				rem_q <= add_carry ? add_sum : {rem_q[DATA_WIDTH-2:0], a_q[DATA_WIDTH-1]};
				a_q   <= {a_q[DATA_WIDTH-2:0], add_carry};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_FIX: res_q <= fix_neg ? add_sum : fix_val;
			ST_MUL: begin
				if (mp_q == '0) begin
					case (mk_q)
						MK_ACC: begin
							acc_q   <= prod_q;
							pw_sq_q <= 1'b1;
						end
						MK_SQ: begin
							a_q     <= prod_q;
							b_q     <= b_q >> 1;
							pw_sq_q <= 1'b0;
						end
						default: res_q <= prod_q;
					endcase
				end else begin
					if (mp_q[0]) begin
						prod_q <= add_sum;
					end
					mc_q <= mc_q << 1;
					mp_q <= mp_q >> 1;
				end
			end
			ST_PWBIT: begin
				prod_q <= '0;
				mc_q   <= a_q;
				if (b_q[0] && !pw_sq_q) begin
					mp_q <= acc_q;
					mk_q <= MK_ACC;
				end else begin
					mp_q  <= a_q;
					mk_q  <= MK_SQ;
					res_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign idle       = (state_q == ST_IDLE);
	assign res        = res_q;
	assign ctl.done   = (state_q == ST_DONE) && out_free;
	assign ctl.status = status_q;
endmodule

FILE: src/integer_calculator_alu_top.sv
// Integer ALU: add, sub, mul, div, mod, power and parity on signed words.
// req carries cmd, operand_a and operand_b; rsp returns result_value and
// status, one rsp item per req item, in order. Both channels move an item
// when valid and ready are high at a rising clock edge.
// One item is worked at a time by a single shared adder under a sequencer;
// req.ready is high only while the sequencer is idle.
// Parity, unused codes, div/mod by zero and power with exponent <= 0 go
// straight to the result; add and sub take a single adder pass.
// Mul steps once per bit of operand_b up to its top set bit (all
// DATA_WIDTH bits when negative). Div and mod take absolute values,
// divide, then fix the sign. Power does one multiply per set exponent bit
// and one square per exponent bit below the top one.
// The shift-add multiply and the restoring divide both use the one adder,
// one bit per cycle.
// A finished result sits in an output register; the next req item is taken
// while it waits. If rsp stalls, the sequencer holds its next result until
// the register frees. Reset clears the sequencer and drops rsp.valid.
module integer_calculator_alu_top #(
	parameter int DATA_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	ica_req_if.sink    req,
	ica_rsp_if.source  rsp
);
	import ica_pkg::*;

	logic                  core_idle, out_free, out_valid_q, out_status_q;
	logic [DATA_WIDTH-1:0] core_res, out_value_q;
	rsp_ctl_t              core_ctl;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = core_idle;

	ica_core #(.DATA_WIDTH(DATA_WIDTH)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req.valid && core_idle),
		.cmd      (req.cmd),
		.a        (req.operand_a),
		.b        (req.operand_b),
		.out_free (out_free),
		.idle     (core_idle),
		.res      (core_res),
		.ctl      (core_ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_ctl.done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_ctl.done) begin
			out_value_q  <= core_res;
			out_status_q <= core_ctl.status;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_value_q;
	assign rsp.status       = out_status_q;
endmodule

FILE: src/ica_chk.sv
module ica_chk #(
	parameter int DATA_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic [DATA_WIDTH-1:0] rsp_value,
	input logic                  rsp_status
);
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req.ready high right after an accepted item");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp.valid dropped while stalled");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> rsp_value == '0)
		else $error("divide by zero result not zero");

	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_valid && req_ready))
		else $error("rsp valid one cycle after accept");
endmodule

bind integer_calculator_alu_top ica_chk #(.DATA_WIDTH(DATA_WIDTH)) u_ica_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_value  (rsp.result_value),
	.rsp_status (rsp.status)
);
